@@ rtl/lzbc_pkg.sv @@
// Package for the LZ back-reference copy engine.
// Holds the history geometry, run limit, status codes, actions and sequencer states.
// No dependencies.
package lzbc_pkg;

	localparam int HIST_DEPTH = 4096;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int MAX_RUN    = 64;
	localparam int RUN_W      = $clog2(MAX_RUN + 1);
	localparam int ALU_W      = 18;

	typedef enum logic [1:0] {
		ACT_LIT    = 2'd0,
		ACT_COPY   = 2'd1,
		ACT_FINISH = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_DIST   = 2'd1,
		ST_OVERFLOW   = 2'd2,
		ST_INCOMPLETE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LIT,
		S_REM,
		S_OVF,
		S_DIST,
		S_RD,
		S_WR,
		S_FIN_STAT
	} seq_state_t;

endpackage

@@ rtl/lzbc_ifs.sv @@
// Valid/ready channel interfaces for the LZ back-reference copy engine.
// Command input, result output and the out_size configuration write channel.
// No dependencies.
interface lzbc_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  literal;
	logic [12:0] distance;
	logic [6:0]  run_length;

	modport source (output valid, action, literal, distance, run_length, input ready);
	modport sink (input valid, action, literal, distance, run_length, output ready);
endinterface

interface lzbc_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        last;
	logic [1:0]  status;
	logic [15:0] total;

	modport source (output valid, out_byte, byte_valid, last, status, total, input ready);
	modport sink (input valid, out_byte, byte_valid, last, status, total, output ready);
endinterface

interface lzbc_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ rtl/lz_backref_copy_engine_core.sv @@
// Top level of the LZ back-reference copy engine.
// Depends on lzbc_pkg, the channel interfaces in lzbc_ifs.sv and lzbc_ram.
//
// The engine takes one decoded command at a time and is not ready while it works on it.
// A literal passes through S_LIT, a status-only command (finish, unused action, zero run or
// any command after a sticky error) through S_FIN_STAT, and a copy runs its checks in
// S_REM, S_OVF and S_DIST, then alternates S_RD and S_WR for each copied byte, since each
// byte is read from the history RAM through its registered read port before it is written
// back in S_WR. All checks and the read address share one subtractor. Results leave through
// an output register, so a stalled sink only holds the engine at the point where it emits.
module lz_backref_copy_engine_core
	import lzbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	lzbc_cfg_if.sink    cfg,
	lzbc_cmd_if.sink    cmd,
	lzbc_res_if.source  res
);

	seq_state_t state_q, state_d;

	logic [15:0]      out_size_q;
	logic [15:0]      produced_q;
	status_t          err_q;
	logic [1:0]       act_q;
	logic [7:0]       lit_q;
	logic [12:0]      dist_q;
	logic [RUN_W-1:0] cnt_q;
	logic [ALU_W-1:0] rem_q;

	logic             res_valid_q;
	logic [7:0]       res_byte_q;
	logic             res_bvalid_q;
	logic             res_last_q;
	status_t          res_status_q;
	logic [15:0]      res_total_q;

	logic [ALU_W-1:0] op_a, op_b, diff;
	logic             neg;
	logic             can_emit;
	logic             cmd_xfer;
	logic [RUN_W-1:0] run_sat;
	logic             dist_bad;

	logic             ram_we, ram_re;
	logic [7:0]       ram_wdata, ram_rdata;

	logic             emit_byte, emit_stat, produce;
	logic [7:0]       emit_val;
	status_t          err_d;

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign can_emit  = !res_valid_q || res.ready;

	assign run_sat = (32'(cmd.run_length) > MAX_RUN) ? RUN_W'(MAX_RUN)
		: cmd.run_length[RUN_W-1:0];

	assign diff = op_a - op_b;
	assign neg  = diff[ALU_W-1];

	assign dist_bad = neg || (dist_q == 13'd0) || (32'(dist_q) > HIST_DEPTH);

	always_comb begin
		op_a = {2'b00, produced_q};
		op_b = {{(ALU_W-13){1'b0}}, dist_q};
		case (state_q)
			S_LIT, S_FIN_STAT: begin
				op_b = {2'b00, out_size_q};
			end
			S_REM: begin
				op_a = {2'b00, out_size_q};
				op_b = {2'b00, produced_q};
			end
			S_OVF: begin
				op_a = rem_q;
				op_b = {{(ALU_W-RUN_W){1'b0}}, cnt_q};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		err_d     = err_q;
		emit_byte = 1'b0;
		emit_stat = 1'b0;
		produce   = 1'b0;
		emit_val  = ram_rdata;
		ram_re    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd_xfer) begin
					if (err_q != ST_OK) begin
						state_d = S_FIN_STAT;
					end else begin
						case (cmd.action)
							ACT_LIT:    state_d = S_LIT;
							ACT_COPY:   state_d = (run_sat == '0) ? S_FIN_STAT : S_REM;
							ACT_FINISH: state_d = S_FIN_STAT;
							default:    state_d = S_FIN_STAT;
						endcase
					end
				end
			end
			S_LIT: begin
				emit_val = lit_q;
				if (!neg) begin
					err_d   = ST_OVERFLOW;
					state_d = S_FIN_STAT;
				end else if (can_emit) begin
					emit_byte = 1'b1;
					produce   = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_REM: begin
				state_d = S_OVF;
			end
			S_OVF: begin
				if (neg) begin
					err_d   = ST_OVERFLOW;
					state_d = S_FIN_STAT;
				end else begin
					state_d = S_DIST;
				end
			end
			S_DIST: begin
				if (dist_bad) begin
					err_d   = ST_BAD_DIST;
					state_d = S_FIN_STAT;
				end else begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				ram_re  = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				if (can_emit) begin
					emit_byte = 1'b1;
					produce   = 1'b1;
					state_d   = (cnt_q == RUN_W'(1)) ? S_IDLE : S_RD;
				end
			end
			S_FIN_STAT: begin
				if (act_q == ACT_FINISH && err_q == ST_OK && diff != '0) begin
					err_d = ST_INCOMPLETE;
				end
				if (can_emit) begin
					emit_stat = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign ram_we    = produce;
	assign ram_wdata = emit_val;

	lzbc_ram #(
		.WIDTH (8),
		.DEPTH (HIST_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (produced_q[HIST_AW-1:0]),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (diff[HIST_AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_size_q  <= 16'hFFFF;
			produced_q  <= '0;
			err_q       <= ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
			if (cfg.valid && cfg.ready) begin
				out_size_q <= cfg.data;
			end
			if (produce) begin
				produced_q <= produced_q + 16'd1;
			end
			if (emit_byte || emit_stat) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			act_q  <= cmd.action;
			lit_q  <= cmd.literal;
			dist_q <= cmd.distance;
			cnt_q  <= run_sat;
		end else if (state_q == S_WR && produce) begin
			cnt_q <= cnt_q - RUN_W'(1);
		end
		if (state_q == S_REM) begin
			rem_q <= diff;
		end
		if (emit_byte) begin
			res_byte_q   <= emit_val;
			res_bvalid_q <= 1'b1;
			res_last_q   <= (state_q == S_LIT) || (cnt_q == RUN_W'(1));
			res_status_q <= ST_OK;
			res_total_q  <= produced_q + 16'd1;
		end else if (emit_stat) begin
			res_byte_q   <= 8'd0;
			res_bvalid_q <= 1'b0;
			res_last_q   <= 1'b1;
			res_status_q <= err_d;
			res_total_q  <= produced_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.out_byte   = res_byte_q;
	assign res.byte_valid = res_bvalid_q;
	assign res.last       = res_last_q;
	assign res.status     = res_status_q;
	assign res.total      = res_total_q;

endmodule

@@ rtl/lzbc_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the history buffer; no package dependency.
module lzbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
